// ===== sv/fse_pkg.sv =====
// Shared types, widths and codes for the fitness selection engine.
`default_nettype none

package fse_pkg;

	// Fixed field widths of the request and result words.
	localparam int FIT_BITS      = 16;
	localparam int RAND_BITS     = 16;
	localparam int IDX_BITS      = 6;
	localparam int REQ_BITS      = 2;
	localparam int PSIZE_BITS    = 7;
	localparam int TSIZE_BITS    = 5;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 7;

	// Default table depth.
	localparam int POP_DEPTH_DEF = 64;

	// Request type codes.
	localparam logic [REQ_BITS-1:0] REQ_LOAD     = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_ROULETTE = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_TOUR     = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_POP_SIZE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOUR_SIZE = 2'd1;

	// Configuration reset values.
	localparam logic [PSIZE_BITS-1:0] POP_SIZE_RST  = 7'd64;
	localparam logic [TSIZE_BITS-1:0] TOUR_SIZE_RST = 5'd2;

	typedef struct packed {
		logic [REQ_BITS-1:0]  req_type;
		logic [IDX_BITS-1:0]  entry_index;
		logic [FIT_BITS-1:0]  fitness_value;
		logic [RAND_BITS-1:0] random_fraction;
	} req_word_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] selected_index;
		logic [FIT_BITS-1:0] selected_fitness;
	} res_word_t;

	// A finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic      valid;
		res_word_t word;
	} emit_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_WALK,
		ST_TOUR,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== sv/fse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/fse_ctrl.sv =====
// Sequencer and datapath: clearing pass, loads, roulette walk and tournaments.
`default_nettype none

module fse_ctrl
	import fse_pkg::*;
#(
	parameter int POP_DEPTH = POP_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire req_word_t                    req_word,
	input  wire logic [PSIZE_BITS-1:0]        pop_size,
	input  wire logic [TSIZE_BITS-1:0]        tour_size,
	output logic                              mem_we,
	output logic      [$clog2(POP_DEPTH)-1:0] mem_waddr,
	output logic      [FIT_BITS-1:0]          mem_wdata,
	output logic      [$clog2(POP_DEPTH)-1:0] mem_raddr,
	input  wire logic [FIT_BITS-1:0]          mem_rdata,
	output emit_t                             emit,
	input  wire logic                         out_busy
);

	localparam int AW = $clog2(POP_DEPTH);
	localparam int TW = FIT_BITS + AW;
	localparam int PW = TW + RAND_BITS;
	localparam int XW = (AW > IDX_BITS) ? AW : IDX_BITS;
	localparam int CW = (AW + 1 > PSIZE_BITS) ? AW + 1 : PSIZE_BITS;
	localparam logic [AW-1:0] LAST = AW'(POP_DEPTH - 1);

	state_t                state_q, state_d;
	logic [AW-1:0]         clr_q;
	req_word_t             req_q;
	logic                  inrange_q;
	logic [TW-1:0]         total_q;
	logic [TW-1:0]         thr_q;
	logic [TW-1:0]         acc_q;
	logic [AW-1:0]         walk_q;
	logic [AW-1:0]         nm1_q;
	logic [IDX_BITS-1:0]   best_idx_q;
	logic [FIT_BITS-1:0]   best_fit_q;
	logic [TSIZE_BITS-1:0] tcnt_q;
	logic [IDX_BITS-1:0]   emit_idx_q;
	logic [FIT_BITS-1:0]   emit_fit_q;

	logic                  accept;
	logic [XW-1:0]         in_idx_x;
	logic                  in_range;
	logic [XW-1:0]         cap_idx_x;
	logic [CW-1:0]         ps_x;
	logic [CW-1:0]         nm1_x;
	logic [AW-1:0]         nm1_c;
	logic [PW-1:0]         prod;
	logic [TW-1:0]         walk_sum;
	logic                  walk_hit;
	logic [XW-1:0]         walk_x;
	logic [FIT_BITS-1:0]   tour_fit;
	logic                  tour_take;
	logic [IDX_BITS-1:0]   best_idx_n;
	logic [FIT_BITS-1:0]   best_fit_n;
	logic [TSIZE_BITS-1:0] tcnt_n;
	logic [TSIZE_BITS-1:0] tsize;
	logic                  tour_done;

	// One word at a time: new words are taken only in the idle state.
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid & ~req_stall;

	// Entry index widened to the table address and range-checked.
	assign in_idx_x  = XW'(req_word.entry_index);
	assign in_range  = ({1'b0, in_idx_x} < (XW + 1)'(POP_DEPTH));
	assign cap_idx_x = XW'(req_q.entry_index);

	// Last entry of the walk, with the population size clamped to the table.
	always_comb begin
		ps_x = CW'(pop_size);
		if (ps_x == '0) begin
			nm1_x = '0;
		end else if (ps_x > CW'(POP_DEPTH)) begin
			nm1_x = CW'(POP_DEPTH - 1);
		end else begin
			nm1_x = ps_x - CW'(1);
		end
		nm1_c = nm1_x[AW-1:0];
	end

	// Threshold product, registered before the walk starts.
	assign prod = PW'(total_q) * PW'(req_q.random_fraction);

	// One walk step: add the entry just read and compare with the threshold.
	assign walk_sum = acc_q + TW'(mem_rdata);
	assign walk_hit = (walk_sum >= thr_q);
	assign walk_x   = XW'(walk_q);

	// Tournament step: the best fitness wins, ties keep the earlier contestant.
	always_comb begin
		tour_fit   = inrange_q ? mem_rdata : '0;
		tour_take  = (tcnt_q == '0) || (tour_fit > best_fit_q);
		best_idx_n = tour_take ? req_q.entry_index : best_idx_q;
		best_fit_n = tour_take ? tour_fit : best_fit_q;
		tcnt_n     = tcnt_q + TSIZE_BITS'(1);
		tsize      = (tour_size == '0) ? TSIZE_BITS'(1) : tour_size;
		tour_done  = (tcnt_n >= tsize);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req_word.req_type)
						REQ_LOAD:     state_d = ST_LOAD;
						REQ_ROULETTE: state_d = ST_MUL;
						REQ_TOUR:     state_d = ST_TOUR;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: state_d = ST_IDLE;
			ST_MUL:  state_d = ST_WALK;
			ST_WALK: begin
				if (walk_hit || (walk_q == nm1_q)) begin
					state_d = ST_EMIT;
				end
			end
			ST_TOUR: state_d = tour_done ? ST_EMIT : ST_IDLE;
			ST_EMIT: begin
				if (!out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port and result outputs.
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = cap_idx_x[AW-1:0];
		mem_wdata  = req_q.fitness_value;
		mem_raddr  = cap_idx_x[AW-1:0];
		emit.valid = 1'b0;
		emit.word.selected_index   = emit_idx_q;
		emit.word.selected_fitness = emit_fit_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: mem_raddr = in_idx_x[AW-1:0];
			ST_LOAD: mem_we    = inrange_q;
			ST_MUL:  mem_raddr = '0;
			ST_WALK: mem_raddr = walk_q + AW'(1);
			ST_EMIT: emit.valid = 1'b1;
			default: ;
		endcase
	end

	// Control state, table total and tournament state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			total_q    <= '0;
			best_idx_q <= '0;
			best_fit_q <= '0;
			tcnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_LOAD && inrange_q) begin
				total_q <= total_q - TW'(mem_rdata) + TW'(req_q.fitness_value);
			end
			if (state_q == ST_TOUR) begin
				best_idx_q <= best_idx_n;
				best_fit_q <= best_fit_n;
				tcnt_q     <= tour_done ? '0 : tcnt_n;
			end
		end
	end

	// Captured word, walk registers and the pending result.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_word;
			inrange_q <= in_range;
		end
		case (state_q)
			ST_MUL: begin
				thr_q  <= prod[PW-1:RAND_BITS];
				acc_q  <= '0;
				walk_q <= '0;
				nm1_q  <= nm1_c;
			end
			ST_WALK: begin
				acc_q      <= walk_sum;
				walk_q     <= walk_q + AW'(1);
				emit_idx_q <= walk_x[IDX_BITS-1:0];
				emit_fit_q <= mem_rdata;
			end
			ST_TOUR: begin
				emit_idx_q <= best_idx_n;
				emit_fit_q <= best_fit_n;
			end
			default: ;
		endcase
	end

	// The walk never runs past the last entry in use.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (walk_q <= nm1_q))
		else $error("roulette walk passed the last entry in use");

	// A walk that neither hits nor ends keeps going with the grown sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && !walk_hit && walk_q != nm1_q)
		|=> (state_q == ST_WALK) && (acc_q == $past(walk_sum)))
		else $error("roulette walk stopped early or lost its sum");

	// Each contestant advances the count by one or closes the tournament.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOUR)
		|=> (tcnt_q == '0) || (tcnt_q == $past(tcnt_q) + TSIZE_BITS'(1)))
		else $error("tournament count stepped wrongly");

endmodule

`default_nettype wire

// ===== sv/fse_out.sv =====
// Output register that holds one result word until the consumer takes it.
`default_nettype none

module fse_out
	import fse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire emit_t     emit,
	output logic           out_busy,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_word_t      res_word
);

	logic      valid_q;
	res_word_t word_q;
	logic      load;

	// The register is busy only while a word waits and the consumer stalls.
	assign out_busy = valid_q & res_stall;
	assign load     = emit.valid & ~out_busy;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= emit.word;
		end
	end

	assign res_valid = valid_q;
	assign res_word  = word_q;

	// A new result never replaces one that is still stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || !res_stall))
		else $error("result word overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/fitness_selection_engine.sv =====
// Top level of the fitness selection engine: configuration, table RAM and sequencer.
//
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | req_word (load, roulette, tour)
//  res     | out       | res_valid/res_stall  | res_word (index, fitness)
//  cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A load passes through ST_LOAD, a tournament contestant through ST_TOUR (and
// ST_EMIT when it closes the tournament), and a roulette query through ST_MUL, a
// walk over k entries (1 up to the population size in use) and ST_EMIT: the single
// table read port delivers one entry per cycle. After reset a clearing pass writes
// zero to all POP_DEPTH table entries with req_stall high; cfg_ready is always high.
// A stalled result sits in the output register and the block goes on taking loads
// and contestants; the next result waits until that register is free.
`default_nettype none

module fitness_selection_engine
	import fse_pkg::*;
#(
	parameter int POP_DEPTH = POP_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     req_valid,
	output logic                          req_stall,
	input  wire req_word_t                req_word,
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output res_word_t                     res_word,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int AW = $clog2(POP_DEPTH);

	logic [PSIZE_BITS-1:0] pop_size_q;
	logic [TSIZE_BITS-1:0] tour_size_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [FIT_BITS-1:0]   mem_wdata;
	logic [AW-1:0]         mem_raddr;
	logic [FIT_BITS-1:0]   mem_rdata;
	emit_t                 emit;
	logic                  out_busy;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q  <= POP_SIZE_RST;
			tour_size_q <= TOUR_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POP_SIZE:  pop_size_q  <= cfg_data[PSIZE_BITS-1:0];
				CFG_TOUR_SIZE: tour_size_q <= cfg_data[TSIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Fitness table.
	fse_ram #(
		.WIDTH (FIT_BITS),
		.DEPTH (POP_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer and datapath.
	fse_ctrl #(
		.POP_DEPTH (POP_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.pop_size  (pop_size_q),
		.tour_size (tour_size_q),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.emit      (emit),
		.out_busy  (out_busy)
	);

	// Output register.
	fse_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.out_busy  (out_busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the fitness selection engine: directed rows, then random phases.

module tb;
	import fse_pkg::*;

	// Request code the block must ignore, and register indexes with no register behind them.
	localparam logic [REQ_BITS-1:0]     REQ_NONE    = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

	localparam int IDLE_PCT     = 17;
	localparam int SETTLE_CYC   = 8;
	localparam int TAIL_CYC     = 100;
	localparam int HOLD_CYC     = 400;
	localparam int PHASE_WORDS  = 96;
	localparam int PHASE_COUNT  = 12;
	localparam int CYCLE_LIMIT  = 600000;

	// One row of the directed part: either a register write or a request word.
	typedef struct {
		bit                       is_cfg;
		logic [CFG_IDX_BITS-1:0]  cfg_idx;
		logic [CFG_DATA_BITS-1:0] cfg_val;
		req_word_t                word;
		bit                       has_want;
		res_word_t                want;
	} dir_row_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     req_valid = 1'b0;
	logic                     req_stall;
	req_word_t                req_word  = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	res_word_t                res_word;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	// Mirror of the block's table, total, tournament and registers.
	logic [FIT_BITS-1:0]   fit_tab [POP_DEPTH_DEF];
	logic [21:0]           fit_sum;
	logic [IDX_BITS-1:0]   best_idx;
	logic [FIT_BITS-1:0]   best_fit;
	logic [4:0]            contest_cnt;
	logic [PSIZE_BITS-1:0] pop_size_m;
	logic [TSIZE_BITS-1:0] tour_size_m;

	res_word_t pick_queue [$];
	dir_row_t  directed_rows [$];
	int        mismatches  = 0;
	int        cycle_count = 0;
	int        hold_left   = 0;
	bit        hold_req    = 1'b0;
	bit        hold_done   = 1'b0;
	bit        calm        = 1'b0;

	int pop_plan  [9] = '{64, 1, 127, 0, 64, 17, 100, 2, 40};
	int tour_plan [9] = '{2, 1, 31, 0, 16, 3, 4, 7, 1};

	fitness_selection_engine u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	// Register write as the block sees it; unknown indexes change nothing.
	task automatic apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		if (idx == CFG_POP_SIZE) begin
			pop_size_m = val[PSIZE_BITS-1:0];
		end else if (idx == CFG_TOUR_SIZE) begin
			tour_size_m = val[TSIZE_BITS-1:0];
		end
	endtask

	// Works out the selection caused by one accepted request and queues it.
	task automatic predict_selection(input req_word_t w, input bit has_want,
			input res_word_t want);
		res_word_t       r;
		bit              got;
		int              n;
		int              pick;
		int              tsize;
		longint unsigned thr;
		longint unsigned acc;
		logic [FIT_BITS-1:0] f;
		got = 1'b0;
		r   = '0;
		case (w.req_type)
			REQ_LOAD: begin
				fit_sum = fit_sum - 22'(fit_tab[w.entry_index]) + 22'(w.fitness_value);
				fit_tab[w.entry_index] = w.fitness_value;
			end
			REQ_ROULETTE: begin
				n = int'(pop_size_m);
				if (n < 1) n = 1;
				if (n > POP_DEPTH_DEF) n = POP_DEPTH_DEF;
				thr  = (longint'(fit_sum) * longint'(w.random_fraction)) >> RAND_BITS;
				acc  = 0;
				pick = n - 1;
				for (int j = 0; j < n; j++) begin
					acc += 64'(fit_tab[j]);
					if (acc >= thr) begin
						pick = j;
						break;
					end
				end
				r.selected_index   = pick[IDX_BITS-1:0];
				r.selected_fitness = fit_tab[pick];
				got = 1'b1;
			end
			REQ_TOUR: begin
				f     = fit_tab[w.entry_index];
				tsize = (tour_size_m == '0) ? 1 : int'(tour_size_m);
				if (contest_cnt == '0 || f > best_fit) begin
					best_idx = w.entry_index;
					best_fit = f;
				end
				contest_cnt = contest_cnt + 5'd1;
				if (int'(contest_cnt) >= tsize) begin
					r.selected_index   = best_idx;
					r.selected_fitness = best_fit;
					contest_cnt = '0;
					got = 1'b1;
				end
			end
			default: ;
		endcase
		if (got) pick_queue.push_back(has_want ? want : r);
	endtask

	// Offers one word with random idle cycles ahead of it and waits until it is taken.
	task automatic offer_req(input req_word_t w, input bit has_want, input res_word_t want);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predict_selection(w, has_want, want);
	endtask

	// Leaves valid low until every pending selection is out and the block has settled.
	task automatic wait_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pick_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Holds a register write until it is taken; valid is lowered by the caller.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, val);
	endtask

	function automatic dir_row_t req_row(input logic [REQ_BITS-1:0] rt,
			input logic [IDX_BITS-1:0] idx, input logic [FIT_BITS-1:0] fv,
			input logic [RAND_BITS-1:0] u);
		dir_row_t row;
		row = '{default: '0};
		row.word.req_type        = rt;
		row.word.entry_index     = idx;
		row.word.fitness_value   = fv;
		row.word.random_fraction = u;
		return row;
	endfunction

	function automatic dir_row_t want_row(input logic [REQ_BITS-1:0] rt,
			input logic [IDX_BITS-1:0] idx, input logic [RAND_BITS-1:0] u,
			input logic [IDX_BITS-1:0] wi, input logic [FIT_BITS-1:0] wf);
		dir_row_t row;
		row = req_row(rt, idx, '0, u);
		row.has_want              = 1'b1;
		row.want.selected_index   = wi;
		row.want.selected_fitness = wf;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		dir_row_t row;
		row = '{default: '0};
		row.is_cfg  = 1'b1;
		row.cfg_idx = idx;
		row.cfg_val = val;
		return row;
	endfunction

	// Random request: loads, queries, contestants, ignored codes; extremes and small values mixed in.
	function automatic req_word_t rand_req();
		req_word_t w;
		int        sel;
		sel = $urandom_range(99);
		w.req_type = (sel < 40) ? REQ_LOAD : (sel < 70) ? REQ_ROULETTE :
			(sel < 95) ? REQ_TOUR : REQ_NONE;
		w.entry_index = IDX_BITS'($urandom_range(63));
		case ($urandom_range(9))
			0: w.fitness_value = '0;
			1: w.fitness_value = '1;
			2: w.fitness_value = FIT_BITS'($urandom_range(15));
			default: w.fitness_value = FIT_BITS'($urandom);
		endcase
		case ($urandom_range(9))
			0: w.random_fraction = '0;
			1: w.random_fraction = '1;
			default: w.random_fraction = RAND_BITS'($urandom);
		endcase
		return w;
	endfunction

	// Result side: random stall, plus one long hold-off once the sender asks for it.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			res_stall <= 1'b1;
			hold_left <= HOLD_CYC;
			hold_done <= 1'b1;
		end else begin
			res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Compares each taken result word with the oldest pending selection.
	always @(posedge clk) begin : check_res
		res_word_t exp_w;
		if (arst_n && res_valid && !res_stall) begin
			if (pick_queue.size() == 0) begin
				report_mismatch($sformatf("result with none pending: index %0d fitness %0d",
					res_word.selected_index, res_word.selected_fitness));
			end else begin
				exp_w = pick_queue.pop_front();
				if (res_word.selected_index !== exp_w.selected_index)
					report_mismatch($sformatf("selected_index got %0d want %0d",
						res_word.selected_index, exp_w.selected_index));
				if (res_word.selected_fitness !== exp_w.selected_fitness)
					report_mismatch($sformatf("selected_fitness got %0d want %0d",
						res_word.selected_fitness, exp_w.selected_fitness));
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL fitness_selection_engine");
			$finish;
		end
	end

	initial begin : main
		res_word_t no_want;
		req_word_t w;
		int        sent;
		int        pop_v;
		int        tour_v;
		no_want = '0;

		// State after reset.
		for (int i = 0; i < POP_DEPTH_DEF; i++) fit_tab[i] = '0;
		fit_sum     = '0;
		best_idx    = '0;
		best_fit    = '0;
		contest_cnt = '0;
		pop_size_m  = POP_SIZE_RST;
		tour_size_m = TOUR_SIZE_RST;

		// Empty table, ties, extremes, an ignored code, then register edge cases.
		directed_rows.push_back(want_row(REQ_ROULETTE, 6'd0, 16'h0000, 6'd0, 16'h0000));
		directed_rows.push_back(want_row(REQ_ROULETTE, 6'd63, 16'hFFFF, 6'd0, 16'h0000));
		directed_rows.push_back(req_row(REQ_TOUR, 6'd5, 16'h0000, 16'h0000));
		directed_rows.push_back(want_row(REQ_TOUR, 6'd63, 16'h0000, 6'd5, 16'h0000));
		directed_rows.push_back(req_row(REQ_LOAD, 6'd0, 16'hFFFF, 16'h0000));
		directed_rows.push_back(req_row(REQ_LOAD, 6'd63, 16'hFFFF, 16'hFFFF));
		directed_rows.push_back(req_row(REQ_LOAD, 6'd10, 16'h0001, 16'h0000));
		directed_rows.push_back(want_row(REQ_ROULETTE, 6'd0, 16'h0000, 6'd0, 16'hFFFF));
		directed_rows.push_back(req_row(REQ_ROULETTE, 6'd0, 16'h0000, 16'hFFFF));
		directed_rows.push_back(req_row(REQ_NONE, 6'd42, 16'hAAAA, 16'h5555));
		directed_rows.push_back(req_row(REQ_TOUR, 6'd10, 16'h0000, 16'h0000));
		directed_rows.push_back(want_row(REQ_TOUR, 6'd0, 16'h0000, 6'd0, 16'hFFFF));
		directed_rows.push_back(req_row(REQ_TOUR, 6'd63, 16'h0000, 16'h0000));
		directed_rows.push_back(want_row(REQ_TOUR, 6'd0, 16'h0000, 6'd63, 16'hFFFF));
		directed_rows.push_back(req_row(REQ_LOAD, 6'd0, 16'h0000, 16'h0000));
		directed_rows.push_back(req_row(REQ_ROULETTE, 6'd0, 16'h0000, 16'h8000));
		// One entry in use with no weight: the walk misses and ends on the last entry.
		directed_rows.push_back(cfg_row(CFG_POP_SIZE, 7'd1));
		directed_rows.push_back(cfg_row(CFG_TOUR_SIZE, 7'd1));
		directed_rows.push_back(want_row(REQ_ROULETTE, 6'd0, 16'hFFFF, 6'd0, 16'h0000));
		directed_rows.push_back(want_row(REQ_TOUR, 6'd63, 16'h0000, 6'd63, 16'hFFFF));
		// Zero sizes act as one.
		directed_rows.push_back(cfg_row(CFG_POP_SIZE, 7'd0));
		directed_rows.push_back(cfg_row(CFG_TOUR_SIZE, 7'd0));
		directed_rows.push_back(want_row(REQ_ROULETTE, 6'd0, 16'hFFFF, 6'd0, 16'h0000));
		directed_rows.push_back(want_row(REQ_TOUR, 6'd10, 16'h0000, 6'd10, 16'h0001));
		// Oversized population clamps to the table; tournament size lowered mid-tournament.
		directed_rows.push_back(cfg_row(CFG_POP_SIZE, 7'd127));
		directed_rows.push_back(cfg_row(CFG_TOUR_SIZE, 7'd5));
		directed_rows.push_back(req_row(REQ_ROULETTE, 6'd0, 16'h0000, 16'hFFFF));
		directed_rows.push_back(req_row(REQ_TOUR, 6'd1, 16'h0000, 16'h0000));
		directed_rows.push_back(req_row(REQ_TOUR, 6'd2, 16'h0000, 16'h0000));
		directed_rows.push_back(req_row(REQ_TOUR, 6'd63, 16'h0000, 16'h0000));
		directed_rows.push_back(cfg_row(CFG_TOUR_SIZE, 7'd2));
		directed_rows.push_back(want_row(REQ_TOUR, 6'd0, 16'h0000, 6'd63, 16'hFFFF));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_drain();
				write_reg(directed_rows[i].cfg_idx, directed_rows[i].cfg_val);
				cfg_valid <= 1'b0;
			end else begin
				offer_req(directed_rows[i].word, directed_rows[i].has_want,
					directed_rows[i].want);
			end
		end

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_drain();
			if (p < 9) begin
				pop_v  = pop_plan[p];
				tour_v = tour_plan[p];
			end else begin
				pop_v  = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(1, 64);
				tour_v = $urandom_range(127);
			end
			write_reg(CFG_POP_SIZE, pop_v[CFG_DATA_BITS-1:0]);
			write_reg(CFG_TOUR_SIZE, tour_v[CFG_DATA_BITS-1:0]);
			if (p == 4) begin
				write_reg(CFG_SPARE_A, CFG_DATA_BITS'($urandom_range(127)));
				write_reg(CFG_SPARE_B, CFG_DATA_BITS'($urandom_range(127)));
			end
			cfg_valid <= 1'b0;
			calm = (p == 2);
			sent = 0;
			while (sent < PHASE_WORDS) begin
				if (p == 6 && sent == 12) hold_req = 1'b1;
				w = rand_req();
				offer_req(w, 1'b0, no_want);
				sent++;
			end
		end
		calm = 1'b0;

		wait_drain();
		repeat (TAIL_CYC) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS fitness_selection_engine");
		end else begin
			$display("FAIL fitness_selection_engine");
		end
		$finish;
	end

endmodule
